>>> sv/tcv_pkg.sv
// Shared types, constants and table builders for the tape chorus voice.
package tcv_pkg;

  // Fixed widths of the request and result fields.
  localparam int SAMPLE_W = 16;
  localparam int LFO_W    = 21;
  localparam int IN_W     = 40;   // sample_in + lfo_mod, padded to whole bytes
  localparam int OUT_W    = 16;
  localparam int CFG_W    = 23;   // widest configuration register
  localparam int CFG_AW   = 3;

  // Shared multiplier operand and product widths.
  localparam int MA_W = 26;
  localparam int MB_W = 19;
  localparam int P_W  = MA_W + MB_W;

  // Fixed processing constants.
  localparam int GUARD_SAMPLES      = 4;
  localparam int LFO_SMOOTH_SHIFT   = 8;
  localparam int RATIO_SMOOTH_SHIFT = 6;
  localparam int RATIO_LIMIT        = 167772;
  localparam int DAMP_SHIFT         = 15;
  localparam int WET_GAIN           = 5120;
  localparam int DRIVE_UNITY        = 4096;
  localparam int DIV_STEPS          = 15;

  // Register indexes.
  localparam logic [CFG_AW-1:0] REG_CENTER_DELAY    = 3'd0;
  localparam logic [CFG_AW-1:0] REG_WOW_STEP        = 3'd1;
  localparam logic [CFG_AW-1:0] REG_FLUTTER_STEP    = 3'd2;
  localparam logic [CFG_AW-1:0] REG_WOW_DEPTH       = 3'd3;
  localparam logic [CFG_AW-1:0] REG_FLUTTER_DEPTH   = 3'd4;
  localparam logic [CFG_AW-1:0] REG_HERMITE_TENSION = 3'd5;
  localparam logic [CFG_AW-1:0] REG_TONE_COEFF      = 3'd6;
  localparam logic [CFG_AW-1:0] REG_DRIVE_GAIN      = 3'd7;

  typedef enum logic [5:0] {
    ST_CLEAR, ST_IDLE,
    ST_WOW, ST_FLUT, ST_TGT, ST_RATIO, ST_OFS, ST_DAMP, ST_EFF, ST_POS,
    ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_M1, ST_M2, ST_AB,
    ST_H1, ST_H2, ST_H3, ST_H4, ST_H5, ST_H6,
    ST_T1, ST_T2, ST_T3, ST_T4, ST_T5, ST_T6,
    ST_S1, ST_S2, ST_S3, ST_S4, ST_DIV, ST_WR
  } state_t;

  typedef logic [64:0][15:0]  sine_tab_t;
  typedef logic [256:0][15:0] tanh_tab_t;

  localparam logic [63:0] PI_Q30        = 64'd3373259426;
  localparam logic [63:0] TANH_STEP_Q30 = 64'd33543514;
  localparam logic [63:0] ONE_Q30       = 64'd1073741824;

  // Quarter-wave sine, Q15, sin(k*pi/128) by a truncated series.
  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] s;
    for (int k = 0; k <= 64; k++) begin
      x    = (PI_Q30 * 64'(k)) >> 7;
      x2   = (x * x) >> 30;
      term = ONE_Q30;
      term = ONE_Q30 - ((x2 * term) >> 30) / 110;
      term = ONE_Q30 - ((x2 * term) >> 30) / 72;
      term = ONE_Q30 - ((x2 * term) >> 30) / 42;
      term = ONE_Q30 - ((x2 * term) >> 30) / 20;
      term = ONE_Q30 - ((x2 * term) >> 30) / 6;
      s    = (((x * term) >> 30) + 64'd16384) >> 15;
      tab[k] = (s > 64'd32767) ? 16'd32767 : s[15:0];
    end
    return tab;
  endfunction

  // Restoring division, elaboration only.
  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // tanh(k/32) in Q15 by the addition recurrence.
  function automatic tanh_tab_t build_tanh();
    tanh_tab_t tab;
    logic [63:0] t;
    logic [63:0] q;
    t = '0;
    for (int k = 0; k <= 256; k++) begin
      q = (t + 64'd16384) >> 15;
      tab[k] = (q > 64'd32767) ? 16'd32767 : q[15:0];
      t = udiv64((t + TANH_STEP_Q30) << 30, ONE_Q30 + ((t * TANH_STEP_Q30) >> 30));
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();
  localparam tanh_tab_t TANH_TAB = build_tanh();

  // Full-wave sine from the top eight phase bits, Q15 signed.
  function automatic logic signed [16:0] sine_of(logic [23:0] phase);
    logic [5:0]  k;
    logic [1:0]  q;
    logic [15:0] v;
    k = phase[21:16];
    q = phase[23:22];
    v = q[0] ? SINE_TAB[7'd64 - {1'b0, k}] : SINE_TAB[k];
    return q[1] ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

endpackage

>>> sv/tape_chorus_voice.sv
// Tape chorus voice: modulated delay, Hermite read, tone filter, tanh write-back.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tdata: sample_in[15:0], lfo_mod[36:16]
//  m_*      out  m_tvalid/m_tready  m_tdata: sample_out[15:0]
//  cfg_*    in   cfg_we             cfg_addr register index, cfg_wdata value
//
// Requests are taken one at a time, as s_tready is high only in idle. Each runs
// through a chain of states, longer with saturation on than with drive at or below
// unity, set by the single shared multiplier and the 15-step restoring divider for
// the tanh gain correction, plus any wait on m_tready. After rst the delay store
// is cleared one entry a cycle, s_tready low; config writes are taken throughout.
// The result register lets the block go back to idle while a result still waits.
module tape_chorus_voice #(
  parameter int BUFFER_DEPTH = 8192
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [tcv_pkg::IN_W-1:0]   s_tdata,   // [15:0] sample_in, [36:16] lfo_mod
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [tcv_pkg::OUT_W-1:0]  m_tdata,   // [15:0] sample_out
  input  logic                       cfg_we,
  input  logic [tcv_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [tcv_pkg::CFG_W-1:0]  cfg_wdata
);

  localparam int AW    = $clog2(BUFFER_DEPTH);
  localparam int POS_W = AW + 16;
  localparam int CW    = (POS_W + 3 > 30) ? POS_W + 3 : 30;
  localparam logic signed [CW-1:0] LO   = CW'(tcv_pkg::GUARD_SAMPLES) <<< 16;
  localparam logic signed [CW-1:0] HI   =
    CW'(BUFFER_DEPTH - tcv_pkg::GUARD_SAMPLES) <<< 16;
  localparam logic signed [CW-1:0] SPAN = CW'(BUFFER_DEPTH) <<< 16;
  localparam logic [AW-1:0]        LAST = AW'(BUFFER_DEPTH - 1);

  // configuration registers
  logic [20:0] center_delay;
  logic [22:0] wow_step;
  logic [22:0] flutter_step;
  logic [19:0] wow_depth;
  logic [19:0] flutter_depth;
  logic [15:0] hermite_tension;
  logic [15:0] tone_coeff;
  logic [14:0] drive_gain;

  tcv_pkg::state_t state, state_next;

  // voice state
  logic [AW-1:0]        wp;
  logic [23:0]          wow_phase;
  logic [23:0]          flutter_phase;
  logic signed [23:0]   smoothed_lfo;
  logic signed [23:0]   smoothed_ratio;
  logic signed [CW-1:0] read_offset;
  logic signed [23:0]   tone_one;
  logic signed [23:0]   tone_two;

  // per-request working registers
  logic signed [15:0]   x_in;
  logic signed [20:0]   lfo_in;
  logic signed [21:0]   wow_v;
  logic signed [23:0]   target;
  logic signed [CW-1:0] eff;
  logic [AW-1:0]        i1;
  logic [15:0]          frac_t;
  logic signed [15:0]   p0, p1, p2, p3;
  logic signed [23:0]   m1;
  logic signed [23:0]   ha, hb;
  logic signed [25:0]   hr;
  logic [7:0]           sat_i;
  logic [9:0]           sat_fr;
  logic [15:0]          rem;
  logic [14:0]          dlow;
  logic [14:0]          quo;
  logic [3:0]           div_cnt;
  logic [15:0]          out_r;

  // shared multiplier
  logic signed [tcv_pkg::MA_W-1:0] mul_a;
  logic signed [tcv_pkg::MB_W-1:0] mul_b;
  logic signed [tcv_pkg::P_W-1:0]  prod;

  // delay store
  logic [15:0]   store [BUFFER_DEPTH];
  logic [AW-1:0] rd_addr;
  logic [15:0]   rd_data;
  logic          wr_en;
  logic [15:0]   wr_data;

  logic accept;
  logic out_free;
  logic bypass;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign bypass   = drive_gain <= 15'(tcv_pkg::DRIVE_UNITY);
  assign s_tready = (state == tcv_pkg::ST_IDLE);
  assign m_tdata  = out_r;

  // centre delay in Q16, clamped to the guard bounds
  logic signed [CW-1:0] centre_raw, centre;
  assign centre_raw = $signed(CW'({center_delay, 8'b0}));
  assign centre     = (centre_raw < LO) ? LO : ((centre_raw > HI) ? HI : centre_raw);

  // ---------------- combinational datapath helpers ----------------
  logic signed [25:0]   tgt_sum;
  logic signed [CW-1:0] ro_mag, ro_damp, eff_raw, pos_raw, pos_w;
  logic [AW:0]          i1_p1, i1_p2;
  logic signed [23:0]   m2v;
  logic signed [25:0]   h_sum;
  logic signed [25:0]   o_full;
  logic [16:0]          x_mag;
  logic [15:0]          t_lo, t_hi, tv;
  logic [15:0]          rem_sh;
  logic                 div_ge;
  logic [15:0]          sat_val;

  assign tgt_sum  = 26'(smoothed_lfo) + 26'(wow_v) + 26'(prod >>> 15);
  assign ro_mag   = (read_offset < 0) ? -read_offset : read_offset;
  assign ro_damp  = ro_mag >>> tcv_pkg::DAMP_SHIFT;
  assign eff_raw  = centre + read_offset;
  assign pos_raw  = $signed(CW'({wp, 16'b0})) - eff;
  assign pos_w    = (pos_raw < 0) ? pos_raw + SPAN : pos_raw;
  assign i1_p1    = (i1 == LAST) ? '0 : {1'b0, i1} + 1'b1;
  assign i1_p2    = (i1_p1[AW-1:0] == LAST) ? '0 : {1'b0, i1_p1[AW-1:0]} + 1'b1;
  assign m2v      = 24'(prod >>> 15);
  assign h_sum    = 26'(prod >>> 16) + 26'(p1);
  assign o_full   = 26'(prod >>> 12);
  assign x_mag    = x_in[15] ? 17'(-(17'(x_in))) : 17'(x_in);
  assign t_lo     = tcv_pkg::TANH_TAB[{1'b0, sat_i}];
  assign t_hi     = tcv_pkg::TANH_TAB[9'({1'b0, sat_i}) + 9'd1];
  assign tv       = t_lo + 16'(prod >>> 10);
  assign rem_sh   = {rem[14:0], dlow[14]};
  assign div_ge   = rem_sh >= {1'b0, drive_gain};
  assign sat_val  = bypass ? x_in : (x_in[15] ? 16'(-{1'b0, quo}) : {1'b0, quo});

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    case (state)
      tcv_pkg::ST_CLEAR: if (wp == LAST) state_next = tcv_pkg::ST_IDLE;
      tcv_pkg::ST_IDLE:  if (accept) state_next = tcv_pkg::ST_WOW;
      tcv_pkg::ST_WOW:   state_next = tcv_pkg::ST_FLUT;
      tcv_pkg::ST_FLUT:  state_next = tcv_pkg::ST_TGT;
      tcv_pkg::ST_TGT:   state_next = tcv_pkg::ST_RATIO;
      tcv_pkg::ST_RATIO: state_next = tcv_pkg::ST_OFS;
      tcv_pkg::ST_OFS:   state_next = tcv_pkg::ST_DAMP;
      tcv_pkg::ST_DAMP:  state_next = tcv_pkg::ST_EFF;
      tcv_pkg::ST_EFF:   state_next = tcv_pkg::ST_POS;
      tcv_pkg::ST_POS:   state_next = tcv_pkg::ST_RD0;
      tcv_pkg::ST_RD0:   state_next = tcv_pkg::ST_RD1;
      tcv_pkg::ST_RD1:   state_next = tcv_pkg::ST_RD2;
      tcv_pkg::ST_RD2:   state_next = tcv_pkg::ST_RD3;
      tcv_pkg::ST_RD3:   state_next = tcv_pkg::ST_M1;
      tcv_pkg::ST_M1:    state_next = tcv_pkg::ST_M2;
      tcv_pkg::ST_M2:    state_next = tcv_pkg::ST_AB;
      tcv_pkg::ST_AB:    state_next = tcv_pkg::ST_H1;
      tcv_pkg::ST_H1:    state_next = tcv_pkg::ST_H2;
      tcv_pkg::ST_H2:    state_next = tcv_pkg::ST_H3;
      tcv_pkg::ST_H3:    state_next = tcv_pkg::ST_H4;
      tcv_pkg::ST_H4:    state_next = tcv_pkg::ST_H5;
      tcv_pkg::ST_H5:    state_next = tcv_pkg::ST_H6;
      tcv_pkg::ST_H6:    state_next = tcv_pkg::ST_T1;
      tcv_pkg::ST_T1:    state_next = tcv_pkg::ST_T2;
      tcv_pkg::ST_T2:    state_next = tcv_pkg::ST_T3;
      tcv_pkg::ST_T3:    state_next = tcv_pkg::ST_T4;
      tcv_pkg::ST_T4:    state_next = tcv_pkg::ST_T5;
      tcv_pkg::ST_T5:    state_next = tcv_pkg::ST_T6;
      tcv_pkg::ST_T6:    if (out_free) state_next = tcv_pkg::ST_S1;
      tcv_pkg::ST_S1:    state_next = bypass ? tcv_pkg::ST_WR : tcv_pkg::ST_S2;
      tcv_pkg::ST_S2:    state_next = tcv_pkg::ST_S3;
      tcv_pkg::ST_S3:    state_next = tcv_pkg::ST_S4;
      tcv_pkg::ST_S4:    state_next = tcv_pkg::ST_DIV;
      tcv_pkg::ST_DIV:
        if (div_cnt == 4'(tcv_pkg::DIV_STEPS - 1)) state_next = tcv_pkg::ST_WR;
      tcv_pkg::ST_WR:    state_next = tcv_pkg::ST_IDLE;
      default:           state_next = tcv_pkg::ST_IDLE;
    endcase
  end

  // ---------------- multiplier operands, store port controls ----------------
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    rd_addr = i1;
    wr_en   = 1'b0;
    wr_data = sat_val;
    case (state)
      tcv_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = '0;
      end
      tcv_pkg::ST_WOW: begin
        mul_a = $signed(26'(wow_depth));
        mul_b = 19'(tcv_pkg::sine_of(wow_phase));
      end
      tcv_pkg::ST_FLUT: begin
        mul_a = $signed(26'(flutter_depth));
        mul_b = 19'(tcv_pkg::sine_of(flutter_phase));
      end
      tcv_pkg::ST_RD0:   rd_addr = (i1 == '0) ? LAST : i1 - 1'b1;
      tcv_pkg::ST_RD1:   rd_addr = i1;
      tcv_pkg::ST_RD2:   rd_addr = i1_p1[AW-1:0];
      tcv_pkg::ST_RD3:   rd_addr = i1_p2[AW-1:0];
      tcv_pkg::ST_M1: begin
        mul_a = $signed(26'(hermite_tension));
        mul_b = 19'(17'(p2) - 17'(p0));
      end
      tcv_pkg::ST_M2: begin
        mul_a = $signed(26'(hermite_tension));
        mul_b = 19'(17'(p3) - 17'(p1));
      end
      tcv_pkg::ST_H1: begin
        mul_a = 26'(ha);
        mul_b = $signed(19'(frac_t));
      end
      tcv_pkg::ST_H3, tcv_pkg::ST_H5: begin
        mul_a = hr;
        mul_b = $signed(19'(frac_t));
      end
      tcv_pkg::ST_T1: begin
        mul_a = hr - 26'(tone_one);
        mul_b = $signed(19'(17'h10000 - 17'(tone_coeff)));
      end
      tcv_pkg::ST_T3: begin
        mul_a = 26'(tone_one) - 26'(tone_two);
        mul_b = $signed(19'(17'h10000 - 17'(tone_coeff)));
      end
      tcv_pkg::ST_T5, tcv_pkg::ST_T6: begin
        mul_a = 26'(tone_two);
        mul_b = 19'(tcv_pkg::WET_GAIN);
      end
      tcv_pkg::ST_S1: begin
        mul_a = $signed(26'(drive_gain));
        mul_b = $signed(19'(x_mag));
      end
      tcv_pkg::ST_S3: begin
        mul_a = $signed(26'(t_hi - t_lo));
        mul_b = $signed(19'(sat_fr));
      end
      tcv_pkg::ST_WR:    wr_en = 1'b1;
      default: ;
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;

    if (rst) begin
      center_delay    <= 21'd122880;
      wow_step        <= 23'd115;
      flutter_step    <= 23'd2027;
      wow_depth       <= 20'd18455;
      flutter_depth   <= 20'd9227;
      hermite_tension <= 16'd16384;
      tone_coeff      <= 16'd10500;
      drive_gain      <= 15'd4096;
    end else if (cfg_we) begin
      case (cfg_addr)
        tcv_pkg::REG_CENTER_DELAY:    center_delay    <= cfg_wdata[20:0];
        tcv_pkg::REG_WOW_STEP:        wow_step        <= cfg_wdata[22:0];
        tcv_pkg::REG_FLUTTER_STEP:    flutter_step    <= cfg_wdata[22:0];
        tcv_pkg::REG_WOW_DEPTH:       wow_depth       <= cfg_wdata[19:0];
        tcv_pkg::REG_FLUTTER_DEPTH:   flutter_depth   <= cfg_wdata[19:0];
        tcv_pkg::REG_HERMITE_TENSION: hermite_tension <= cfg_wdata[15:0];
        tcv_pkg::REG_TONE_COEFF:      tone_coeff      <= cfg_wdata[15:0];
        tcv_pkg::REG_DRIVE_GAIN:      drive_gain      <= cfg_wdata[14:0];
        default: ;
      endcase
    end

    if (rst) begin
      state          <= tcv_pkg::ST_CLEAR;
      wp             <= '0;
      wow_phase      <= '0;
      flutter_phase  <= '0;
      smoothed_lfo   <= '0;
      smoothed_ratio <= '0;
      read_offset    <= '0;
      tone_one       <= '0;
      tone_two       <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      state <= state_next;
      // a result taken in the same cycle as a new one is loaded stays valid
      if (m_tvalid && m_tready && !((state == tcv_pkg::ST_T6) && out_free))
        m_tvalid <= 1'b0;

      case (state)
        tcv_pkg::ST_CLEAR: wp <= (wp == LAST) ? '0 : wp + 1'b1;
        tcv_pkg::ST_IDLE: if (accept) begin
          x_in          <= $signed(s_tdata[15:0]);
          lfo_in        <= $signed(s_tdata[36:16]);
          wow_phase     <= wow_phase + 24'(wow_step);
          flutter_phase <= flutter_phase + 24'(flutter_step);
        end
        tcv_pkg::ST_WOW:
          smoothed_lfo <= smoothed_lfo +
            24'((25'(lfo_in) - 25'(smoothed_lfo)) >>> tcv_pkg::LFO_SMOOTH_SHIFT);
        tcv_pkg::ST_FLUT:  wow_v <= 22'(prod >>> 15);
        tcv_pkg::ST_TGT: begin
          // clamp the target ratio deviation to about +-2 %
          if (tgt_sum > 26'(tcv_pkg::RATIO_LIMIT))
            target <= 24'(tcv_pkg::RATIO_LIMIT);
          else if (tgt_sum < -26'(tcv_pkg::RATIO_LIMIT))
            target <= -24'(tcv_pkg::RATIO_LIMIT);
          else
            target <= 24'(tgt_sum);
        end
        tcv_pkg::ST_RATIO:
          smoothed_ratio <= smoothed_ratio +
            24'((25'(target) - 25'(smoothed_ratio)) >>> tcv_pkg::RATIO_SMOOTH_SHIFT);
        tcv_pkg::ST_OFS:
          read_offset <= read_offset - CW'(smoothed_ratio >>> 7);
        tcv_pkg::ST_DAMP:
          read_offset <= (read_offset < 0) ? read_offset + ro_damp : read_offset - ro_damp;
        tcv_pkg::ST_EFF:
          eff <= (eff_raw < LO) ? LO : ((eff_raw > HI) ? HI : eff_raw);
        tcv_pkg::ST_POS: begin
          // anti-windup: offset follows the clamped delay
          read_offset <= eff - centre;
          i1          <= pos_w[POS_W-1:16];
          frac_t      <= pos_w[15:0];
        end
        tcv_pkg::ST_RD1:   p0 <= rd_data;
        tcv_pkg::ST_RD2:   p1 <= rd_data;
        tcv_pkg::ST_RD3:   p2 <= rd_data;
        tcv_pkg::ST_M1:    p3 <= rd_data;
        tcv_pkg::ST_M2:    m1 <= 24'(prod >>> 15);
        tcv_pkg::ST_AB: begin
          ha <= (24'(p1) <<< 1) - (24'(p2) <<< 1) + m1 + m2v;
          hb <= ((24'(p2) <<< 1) + 24'(p2)) - ((24'(p1) <<< 1) + 24'(p1))
                - (m1 <<< 1) - m2v;
        end
        tcv_pkg::ST_H2:    hr <= 26'(prod >>> 16) + 26'(hb);
        tcv_pkg::ST_H4:    hr <= 26'(prod >>> 16) + 26'(m1);
        tcv_pkg::ST_H6: begin
          if (h_sum > 26'sd8388607)       hr <= 26'sd8388607;
          else if (h_sum < -26'sd8388608) hr <= -26'sd8388608;
          else                            hr <= h_sum;
        end
        tcv_pkg::ST_T2:    tone_one <= tone_one + 24'(prod >>> 16);
        tcv_pkg::ST_T4:    tone_two <= tone_two + 24'(prod >>> 16);
        tcv_pkg::ST_T6: if (out_free) begin
          m_tvalid <= 1'b1;
          if (o_full > 26'sd32767)       out_r <= 16'h7fff;
          else if (o_full < -26'sd32768) out_r <= 16'h8000;
          else                           out_r <= o_full[15:0];
        end
        tcv_pkg::ST_S2: begin
          sat_i  <= prod[29:22];
          sat_fr <= prod[21:12];
        end
        tcv_pkg::ST_S4: begin
          // tanh value times 4096, divided by the drive
          rem     <= 16'(tv >> 3);
          dlow    <= {tv[2:0], 12'b0};
          quo     <= '0;
          div_cnt <= '0;
        end
        tcv_pkg::ST_DIV: begin
          rem     <= div_ge ? rem_sh - {1'b0, drive_gain} : rem_sh;
          quo     <= {quo[13:0], div_ge};
          dlow    <= {dlow[13:0], 1'b0};
          div_cnt <= div_cnt + 1'b1;
        end
        tcv_pkg::ST_WR:    wp <= (wp == LAST) ? '0 : wp + 1'b1;
        default: ;
      endcase
    end
  end

  // delay store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) store[wp] <= wr_data;
    rd_data <= store[rd_addr];
  end

  // ---------------- assertions ----------------
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("request taken while voice busy");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (state == tcv_pkg::ST_CLEAR) && !m_tvalid)
    else $error("reset did not start clearing pass");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (state == tcv_pkg::ST_T6) && m_tvalid && !m_tready |=> state == tcv_pkg::ST_T6)
    else $error("result overwritten while stalled");

endmodule

>>> sim/tb.sv
// Self-checking testbench for the tape chorus voice: directed and random requests.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 8192;
  // Give margin after the slowest request before config writes and at the end.
  localparam int DRAIN_CYCLES = 120;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [tcv_pkg::IN_W-1:0] s_tdata;    // [15:0] sample_in, [36:16] lfo_mod, zero pad above
  logic m_tvalid;
  logic m_tready;
  logic [tcv_pkg::OUT_W-1:0] m_tdata;   // [15:0] sample_out
  logic cfg_we;
  logic [tcv_pkg::CFG_AW-1:0] cfg_addr;
  logic [tcv_pkg::CFG_W-1:0] cfg_wdata;

  tape_chorus_voice #(.BUFFER_DEPTH(DEPTH)) u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of registers, tables and voice state.
  // ---------------------------------------------------------------------------
  int unsigned cur_center, cur_wow_step, cur_flut_step, cur_wow_depth;
  int unsigned cur_flut_depth, cur_tension, cur_tone, cur_drive;

  shortint    sine_q[65];
  int         tanh_q[257];
  shortint    tape[DEPTH];
  int unsigned head;
  int unsigned wow_ph, flut_ph;
  longint     lfo_avg, ratio_avg, drift, tone_a, tone_b;

  logic [15:0] wet_pending[$];   // expected sample_out values, oldest first
  bit          failed;
  bit          idle_on;          // random gaps on both sides
  int          rx_hold;          // long receiver hold-off, in cycles

  // Quarter sine by a truncated series in Q30, and tanh(k/32) by the addition rule.
  task automatic make_tables();
    longint unsigned x, x2, term, s, t, q;
    longint unsigned dv[5];
    dv[0] = 110; dv[1] = 72; dv[2] = 42; dv[3] = 20; dv[4] = 6;
    for (int k = 0; k <= 64; k++) begin
      x = (64'd3373259426 * k) / 128;
      x2 = (x * x) >> 30;
      term = 64'd1 << 30;
      for (int j = 0; j < 5; j++) term = (64'd1 << 30) - ((x2 * term) >> 30) / dv[j];
      s = (((x * term) >> 30) + 16384) >> 15;
      sine_q[k] = (s > 32767) ? 16'sd32767 : shortint'(s);
    end
    t = 0;
    for (int k = 0; k <= 256; k++) begin
      q = (t + 16384) >> 15;
      tanh_q[k] = (q > 32767) ? 32767 : int'(q);
      t = ((t + 64'd33543514) << 30) / ((64'd1 << 30) + ((t * 64'd33543514) >> 30));
    end
  endtask

  function automatic longint sine_at(int unsigned ph);
    int unsigned idx, k;
    longint v;
    idx = (ph >> 16) & 255;
    k = idx & 63;
    v = ((idx >> 6) & 1) ? sine_q[64 - k] : sine_q[k];
    return ((idx >> 7) & 1) ? -v : v;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Table tanh soft clip applied before the write-back.
  function automatic shortint soft_clip(int x);
    longint mag, y, tv, r;
    int unsigned i, fr;
    if (cur_drive <= tcv_pkg::DRIVE_UNITY) return shortint'(x);
    mag = (x < 0) ? -x : x;
    y = (mag * cur_drive) >> 12;
    i = int'(y >> 10);
    fr = int'(y & 1023);
    if (i >= 256) tv = tanh_q[256];
    else tv = tanh_q[i] + ((longint'(tanh_q[i + 1] - tanh_q[i]) * fr) >>> 10);
    r = (tv * 4096) / cur_drive;
    return shortint'((x < 0) ? -r : r);
  endfunction

  function automatic longint tape_at(longint i);
    return tape[i & (DEPTH - 1)];
  endfunction

  // One sample through the voice; returns the wet output and advances state.
  function automatic logic [15:0] voice_step(logic signed [15:0] dry,
                                             logic signed [20:0] lfo);
    longint lo, hi, span, wow, flut, target, ctr, eff, pos, i1, t, damp;
    longint p0, p1, p2, p3, m1, m2, a, b, r, g1, o;
    lo = longint'(tcv_pkg::GUARD_SAMPLES) * 65536;
    hi = longint'(DEPTH - tcv_pkg::GUARD_SAMPLES) * 65536;
    span = longint'(DEPTH) * 65536;

    wow_ph = (wow_ph + cur_wow_step) & 24'hFFFFFF;
    flut_ph = (flut_ph + cur_flut_step) & 24'hFFFFFF;
    wow = (sine_at(wow_ph) * longint'(cur_wow_depth)) >>> 15;
    flut = (sine_at(flut_ph) * longint'(cur_flut_depth)) >>> 15;

    lfo_avg += (longint'(lfo) - lfo_avg) >>> tcv_pkg::LFO_SMOOTH_SHIFT;
    target = clip(lfo_avg + wow + flut, -tcv_pkg::RATIO_LIMIT, tcv_pkg::RATIO_LIMIT);
    ratio_avg += (target - ratio_avg) >>> tcv_pkg::RATIO_SMOOTH_SHIFT;

    // Integrate speed error into the read offset, then leak it toward zero.
    drift -= ratio_avg >>> 7;
    damp = ((drift < 0) ? -drift : drift) >> tcv_pkg::DAMP_SHIFT;
    drift += (drift < 0) ? damp : -damp;

    // Anti-windup: the offset follows the clamped effective delay.
    ctr = clip(longint'(cur_center) * 256, lo, hi);
    eff = clip(ctr + drift, lo, hi);
    drift = eff - ctr;

    pos = (longint'(head) * 65536 - eff) % span;
    if (pos < 0) pos += span;
    i1 = pos >> 16;
    t = pos & 16'hFFFF;

    p0 = tape_at(i1 - 1); p1 = tape_at(i1); p2 = tape_at(i1 + 1); p3 = tape_at(i1 + 2);
    m1 = ((p2 - p0) * longint'(cur_tension)) >>> 15;
    m2 = ((p3 - p1) * longint'(cur_tension)) >>> 15;
    a = 2 * p1 - 2 * p2 + m1 + m2;
    b = -3 * p1 + 3 * p2 - 2 * m1 - m2;
    r = ((a * t) >>> 16) + b;
    r = ((r * t) >>> 16) + m1;
    r = ((r * t) >>> 16) + p1;
    r = clip(r, -8388608, 8388607);

    g1 = 65536 - longint'(cur_tone);
    tone_a += (g1 * (r - tone_a)) >>> 16;
    tone_b += (g1 * (tone_a - tone_b)) >>> 16;
    o = clip((tone_b * tcv_pkg::WET_GAIN) >>> 12, -32768, 32767);

    tape[head] = soft_clip(int'(dry));
    head = (head + 1) % DEPTH;
    return o[15:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Driver tasks
  // ---------------------------------------------------------------------------
  // Register write; the block must be idle (caller drains first).
  task automatic write_reg(logic [tcv_pkg::CFG_AW-1:0] idx, int unsigned val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val[tcv_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tcv_pkg::REG_CENTER_DELAY:    cur_center = val & 21'h1FFFFF;
      tcv_pkg::REG_WOW_STEP:        cur_wow_step = val & 23'h7FFFFF;
      tcv_pkg::REG_FLUTTER_STEP:    cur_flut_step = val & 23'h7FFFFF;
      tcv_pkg::REG_WOW_DEPTH:       cur_wow_depth = val & 20'hFFFFF;
      tcv_pkg::REG_FLUTTER_DEPTH:   cur_flut_depth = val & 20'hFFFFF;
      tcv_pkg::REG_HERMITE_TENSION: cur_tension = val & 16'hFFFF;
      tcv_pkg::REG_TONE_COEFF:      cur_tone = val & 16'hFFFF;
      tcv_pkg::REG_DRIVE_GAIN:      cur_drive = val & 15'h7FFF;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_all(int unsigned ctr, int unsigned ws, int unsigned fs,
                           int unsigned wd, int unsigned fd, int unsigned ten,
                           int unsigned tone, int unsigned drv);
    write_reg(tcv_pkg::REG_CENTER_DELAY, ctr);
    write_reg(tcv_pkg::REG_WOW_STEP, ws);
    write_reg(tcv_pkg::REG_FLUTTER_STEP, fs);
    write_reg(tcv_pkg::REG_WOW_DEPTH, wd);
    write_reg(tcv_pkg::REG_FLUTTER_DEPTH, fd);
    write_reg(tcv_pkg::REG_HERMITE_TENSION, ten);
    write_reg(tcv_pkg::REG_TONE_COEFF, tone);
    write_reg(tcv_pkg::REG_DRIVE_GAIN, drv);
  endtask

  // Offer one request; valid stays high after acceptance until a gap or drain.
  task automatic send_sample(logic signed [15:0] dry, logic signed [20:0] lfo);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, lfo, dry};
    do @(posedge clk); while (!s_tready);
    wet_pending.push_back(voice_step(dry, lfo));
  endtask

  // Wait until every result is back, then let the block settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (wet_pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [20:0] rand_lfo();
    return 21'($urandom_range(0, 2097151));
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker and receiver backpressure
  // ---------------------------------------------------------------------------
  int stall_left;
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (wet_pending.size() == 0) begin
        $error("sample_out unexpected result %0d", $signed(m_tdata));
        failed = 1'b1;
      end else begin
        logic [15:0] want;
        want = wet_pending.pop_front();
        if (m_tdata !== want) begin
          $error("sample_out expected %0d actual %0d", $signed(want), $signed(m_tdata));
          failed = 1'b1;
        end
      end
    end
    if (rx_hold > 0) begin
      rx_hold--;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset values, field extremes.
  task automatic test_defaults();
    send_sample(16'sh7FFF, 21'sh0FFFFF);
    send_sample(-16'sh8000, -21'sh100000);
    send_sample(16'sh0000, 21'sh000000);
    send_sample(-16'sh0001, -21'sh000001);
    send_sample(16'sh5555, 21'sh0AAAAA);
    send_sample(-16'sh2AAB, 21'sh155555);
    drain();
  endtask

  // Saturation on at max drive and barely above unity; drive below one bypasses.
  task automatic test_saturation();
    write_reg(tcv_pkg::REG_DRIVE_GAIN, 32767);
    send_sample(16'sh7FFF, 0);
    send_sample(-16'sh8000, 0);
    send_sample(16'sh0400, 21'sh0FFFFF);
    send_sample(-16'sh0001, 0);
    drain();
    write_reg(tcv_pkg::REG_DRIVE_GAIN, 4097);
    send_sample(16'sh7FFF, 0);
    send_sample(-16'sh8000, 0);
    drain();
    write_reg(tcv_pkg::REG_DRIVE_GAIN, 0);
    send_sample(16'sh7FFF, 0);
    send_sample(-16'sh8000, 0);
    drain();
  endtask

  // Out-of-range centre delay both ways, tension and tone at their extremes.
  task automatic test_delay_bounds();
    write_all(0, 8388607, 8388607, 1048575, 1048575, 65535, 65535, 4096);
    for (int n = 0; n < 6; n++) send_sample(n[0] ? 16'sh7FFF : -16'sh8000, -21'sh100000);
    drain();
    write_all(2097151, 0, 0, 0, 0, 0, 0, 32767);
    for (int n = 0; n < 6; n++) send_sample(n[0] ? 16'sh7FFF : -16'sh8000, 21'sh0FFFFF);
    drain();
  endtask

  // Random audio under a run of register settings; the random ones use short delays
  // that keep the read position inside the recently written part of the store.
  task automatic test_random_settings();
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_all(122880, 115, 2027, 18455, 9227, 16384, 10500, 4096);
        1: write_all(256, 8388607, 8388607, 1048575, 1048575, 32768, 0, 32767);
        2: write_all(2097151, 0, 0, 0, 0, 0, 65535, 4096);
        default: write_all($urandom_range(256, 8192), $urandom_range(0, 8388607),
                           $urandom_range(0, 8388607), $urandom_range(0, 1048575),
                           $urandom_range(0, 1048575), $urandom_range(0, 65535),
                           $urandom_range(0, 65535), $urandom_range(0, 32767));
      endcase
      for (int n = 0; n < 120; n++) begin
        if ($urandom_range(0, 9) == 0)
          send_sample(16'($urandom_range(0, 65535)), rand_lfo());
        else
          send_sample(16'($urandom_range(0, 65535)),
                      21'($signed(21'($urandom_range(0, 2097151))) >>> 4));
      end
      drain();
    end
  endtask

  // Receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    rx_hold = 400;
    for (int n = 0; n < 40; n++) send_sample(16'($urandom_range(0, 65535)), rand_lfo());
    drain();
  endtask

  // Back-to-back traffic with both sides always ready.
  task automatic test_streaming();
    idle_on = 1'b0;
    write_reg(tcv_pkg::REG_DRIVE_GAIN, $urandom_range(4097, 32767));
    for (int n = 0; n < 200; n++) send_sample(16'($urandom_range(0, 65535)), rand_lfo());
    drain();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    failed = 1'b0;
    idle_on = 1'b1;
    rx_hold = 0;
    stall_left = 0;
    make_tables();
    cur_center = 122880; cur_wow_step = 115; cur_flut_step = 2027;
    cur_wow_depth = 18455; cur_flut_depth = 9227; cur_tension = 16384;
    cur_tone = 10500; cur_drive = 4096;
    foreach (tape[i]) tape[i] = 0;
    head = 0; wow_ph = 0; flut_ph = 0;
    lfo_avg = 0; ratio_avg = 0; drift = 0; tone_a = 0; tone_b = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_defaults();
    test_saturation();
    test_delay_bounds();
    test_random_settings();
    test_backpressure();
    test_streaming();

    if (!failed) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run including the store clear.
  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
